// ----- rtl/waes_pkg.sv -----
package waes_pkg;

    localparam int XY_LIMIT   = 524287;
    localparam int GUARD_BITS = 12;
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SMA_WINDOW  = 2'd0,
        REG_WIND_WINDOW = 2'd1,
        REG_ALPHA       = 2'd2
    } waes_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POLAR,
        ST_POLAR_FIX,
        ST_WRITE,
        ST_EMA,
        ST_WALK,
        ST_DIV,
        ST_VEC,
        ST_DEG,
        ST_OUT
    } waes_state_t;

    typedef struct packed {
        logic load;
        logic polar_start;
        logic polar_fix;
        logic ring_write;
        logic ema_update;
        logic walk_start;
        logic walk_step;
        logic div_start;
        logic div_step;
        logic vec_start;
        logic cordic_step;
        logic deg_calc;
    } waes_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic walk_done;
        logic div_done;
    } waes_sts_t;

    // arctangent table in turn units, 2^32 per turn
    function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
        unique case (i)
            5'd0:  atan_turn = 32'sd536870912;
            5'd1:  atan_turn = 32'sd316933406;
            5'd2:  atan_turn = 32'sd167458907;
            5'd3:  atan_turn = 32'sd85004756;
            5'd4:  atan_turn = 32'sd42667331;
            5'd5:  atan_turn = 32'sd21354465;
            5'd6:  atan_turn = 32'sd10679838;
            5'd7:  atan_turn = 32'sd5340245;
            5'd8:  atan_turn = 32'sd2670163;
            5'd9:  atan_turn = 32'sd1335087;
            5'd10: atan_turn = 32'sd667544;
            5'd11: atan_turn = 32'sd333772;
            5'd12: atan_turn = 32'sd166886;
            5'd13: atan_turn = 32'sd83443;
            5'd14: atan_turn = 32'sd41722;
            5'd15: atan_turn = 32'sd20861;
            5'd16: atan_turn = 32'sd10430;
            5'd17: atan_turn = 32'sd5215;
            5'd18: atan_turn = 32'sd2608;
            5'd19: atan_turn = 32'sd1304;
            5'd20: atan_turn = 32'sd652;
            5'd21: atan_turn = 32'sd326;
            5'd22: atan_turn = 32'sd163;
            5'd23: atan_turn = 32'sd81;
            default: atan_turn = 32'sd0;
        endcase
    endfunction

    // remainder angle (0..89 degrees) in turn units, round(r*2^32/360)
    function automatic logic signed [31:0] deg_to_turn(input logic [6:0] r);
        logic [47:0] p;
        begin
            // 2^32/360 = 11930464.7111; scaled by 2^8 for rounding precision
            p = 48'(r) * 48'd3054198966;
            deg_to_turn = 32'((p + 48'd128) >> 8);
        end
    endfunction

endpackage

// ----- rtl/waes_ctrl.sv -----
module waes_ctrl
    import waes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  waes_sts_t sts,
    output waes_cmd_t cmd
);

    waes_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load        = 1'b1;
                    cmd.polar_start = 1'b1;
                    state_next      = ST_POLAR;
                end
            end
            ST_POLAR:
            begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_done)
                begin
                    state_next = ST_POLAR_FIX;
                end
            end
            ST_POLAR_FIX:
            begin
                cmd.polar_fix = 1'b1;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.ring_write = 1'b1;
                cmd.ema_update = 1'b1;
                state_next     = ST_EMA;
            end
            ST_EMA:
            begin
                cmd.walk_start = 1'b1;
                state_next     = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.vec_start = 1'b1;
                    state_next    = ST_VEC;
                end
            end
            ST_VEC:
            begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_done)
                begin
                    state_next = ST_DEG;
                end
            end
            ST_DEG:
            begin
                cmd.deg_calc = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/waes_dp.sv -----
module waes_dp
    import waes_pkg::*;
#(
    parameter int WINDOW_MAX   = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  waes_cmd_t          cmd,
    output waes_sts_t          sts,
    input  logic [4:0]         sma_window,
    input  logic [4:0]         wind_window,
    input  logic [16:0]        alpha,
    input  logic signed [15:0] sample,
    input  logic               sample_valid,
    input  logic [8:0]         wind_dir_deg,
    input  logic               wind_dir_valid,
    input  logic [11:0]        wind_speed,
    output logic signed [15:0] mean_value,
    output logic [4:0]         mean_count,
    output logic signed [15:0] ema_value,
    output logic [8:0]         wind_dir_avg,
    output logic               wind_fallback
);

    localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int SW    = 16 + CW;          // sample sum width
    localparam int XW    = 20 + CW;          // wind sum width
    localparam int CXW   = XW + 14;          // vectoring datapath width
    localparam int DW    = SW + 1;           // divider operand width

    // ring memories
    logic signed [15:0] smp_mem [WINDOW_MAX];
    logic               smp_ok_mem [WINDOW_MAX];
    logic signed [19:0] wx_mem [WINDOW_MAX];
    logic signed [19:0] wy_mem [WINDOW_MAX];
    logic               wok_mem [WINDOW_MAX];

    logic [CW-1:0] fill_reg;
    logic [PW-1:0] wpos_reg;
    logic signed [31:0] ema_acc_reg;
    logic ema_seeded_reg;

    // latched item
    logic signed [15:0] smp_reg;
    logic               sv_reg;
    logic [8:0]         dir_reg;
    logic               wok_reg;
    logic [1:0]         quad_reg;

    // shared cordic
    logic signed [CXW-1:0] cx_reg, cy_reg;
    logic signed [33:0]    cz_reg;
    logic [4:0]            cstep_reg;
    logic                  cvec_reg;

    logic signed [19:0] nx_reg, ny_reg;

    // walk
    logic [PW-1:0]  ridx_reg;
    logic [CW-1:0]  k_reg;
    logic [CW-1:0]  nsma_reg, nwind_reg;
    logic signed [SW-1:0] sum_reg;
    logic [CW-1:0]  cnt_reg;
    logic signed [XW-1:0] sx_reg, sy_reg;
    logic           any_reg;

    // divider
    logic [DW-1:0]  rem_reg, quo_reg;
    logic [DW-1:0]  dnum_reg;
    logic [CW:0]    dden_reg;
    logic [5:0]     dbit_reg;
    logic           dneg_reg;

    // wrap a direction into 0..359
    logic [8:0] dir_mod;
    assign dir_mod = (wind_dir_deg >= 9'd360) ? wind_dir_deg - 9'd360 : wind_dir_deg;
    logic [8:0] dreg_mod;
    assign dreg_mod = (dir_reg >= 9'd360) ? dir_reg - 9'd360 : dir_reg;

    // quadrant and remainder of incoming direction
    logic [1:0] q_in;
    logic [6:0] r_in;
    always_comb
    begin
        if (dir_mod >= 9'd270)
        begin
            q_in = 2'd3; r_in = 7'(dir_mod - 9'd270);
        end
        else if (dir_mod >= 9'd180)
        begin
            q_in = 2'd2; r_in = 7'(dir_mod - 9'd180);
        end
        else if (dir_mod >= 9'd90)
        begin
            q_in = 2'd1; r_in = 7'(dir_mod - 9'd90);
        end
        else
        begin
            q_in = 2'd0; r_in = 7'(dir_mod);
        end
    end

    logic [43:0] gain_prod;
    assign gain_prod = 44'(wind_speed) * 44'(INV_GAIN_Q32);

    // one cordic iteration
    logic signed [CXW-1:0] sh_x, sh_y;
    logic dir_pos;
    logic signed [33:0] at;
    assign sh_x = cx_reg >>> cstep_reg;
    assign sh_y = cy_reg >>> cstep_reg;
    assign at   = 34'(atan_turn(cstep_reg));
    assign dir_pos = cvec_reg ? cy_reg[CXW-1] : !cz_reg[33];
    assign sts.cordic_done = (cstep_reg == 5'(STEPS - 1));

    // polar rounding
    logic signed [CXW-1:0] rx, ry;
    assign rx = (cx_reg + CXW'(1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    assign ry = (cy_reg + CXW'(1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;

    function automatic logic signed [19:0] sat20(input logic signed [CXW-1:0] v);
        if (v > CXW'(XY_LIMIT)) sat20 = 20'(XY_LIMIT);
        else if (v < -CXW'(XY_LIMIT)) sat20 = -20'(XY_LIMIT);
        else sat20 = 20'(v);
    endfunction

    // window length clamps
    function automatic logic [CW-1:0] wlen(input logic [4:0] r, input logic [CW-1:0] f);
        logic [8:0] n;
        begin
            n = (r == 5'd0) ? 9'd1 : 9'(r);
            if (n > 9'(WINDOW_MAX)) n = 9'(WINDOW_MAX);
            if (n > 9'(f)) n = 9'(f);
            wlen = CW'(n);
        end
    endfunction

    // ema math
    logic [16:0] a_sat;
    logic signed [48:0] ema_sum;
    logic signed [48:0] ema_shift;
    assign a_sat = (alpha > 17'd65536) ? 17'd65536 : alpha;
    assign ema_sum = ((49'($signed({1'b0, a_sat})) * 49'(smp_reg)) <<< 16)
                   + 49'($signed({1'b0, 18'(18'd65536 - 18'(a_sat))})) * 49'(ema_acc_reg)
                   + 49'sd32768;
    assign ema_shift = ema_sum >>> 16;
    logic signed [32:0] ema_rnd;
    assign ema_rnd = (33'(ema_acc_reg) + 33'sd32768) >>> 16;

    logic [PW-1:0] prev_idx;
    assign prev_idx = ridx_reg - PW'(1);
    logic [DW-1:0] rem_sh;
    assign rem_sh = {rem_reg[DW-2:0], dnum_reg[DW-1]};
    assign sts.walk_done = (k_reg >= nsma_reg) && (k_reg >= nwind_reg);
    assign sts.div_done  = (dbit_reg == 6'd0);

    logic signed [33:0] zdeg_full;
    logic signed [42:0] zprod;
    logic signed [42:0] zdeg;
    assign zprod = 43'(cz_reg) * 43'sd360;
    // truncate toward zero
    assign zdeg = (zprod < 0) ? -((-zprod) >>> 32) : (zprod >>> 32);
    assign zdeg_full = 34'(zdeg);

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            wpos_reg       <= '0;
            ema_acc_reg    <= '0;
            ema_seeded_reg <= 1'b0;
            cstep_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                smp_reg  <= sample;
                sv_reg   <= sample_valid;
                dir_reg  <= wind_dir_deg;
                wok_reg  <= wind_dir_valid && (wind_speed != 12'd0);
                quad_reg <= q_in;
            end
            if (cmd.polar_start)
            begin
                cvec_reg  <= 1'b0;
                cstep_reg <= '0;
                cx_reg    <= CXW'(gain_prod >> (32 - 7 - GUARD_BITS));
                cy_reg    <= '0;
                cz_reg    <= 34'(deg_to_turn(r_in));
            end
            else if (cmd.vec_start)
            begin
                cvec_reg  <= 1'b1;
                cstep_reg <= '0;
                if (sx_reg < 0)
                begin
                    cx_reg <= -(CXW'(sx_reg) <<< 12);
                    cy_reg <= -(CXW'(sy_reg) <<< 12);
                    cz_reg <= (sy_reg >= 0) ? 34'sd2147483648 : -34'sd2147483648;
                end
                else
                begin
                    cx_reg <= CXW'(sx_reg) <<< 12;
                    cy_reg <= CXW'(sy_reg) <<< 12;
                    cz_reg <= '0;
                end
            end
            else if (cmd.cordic_step)
            begin
                // rotation: z>=0 subtracts; vectoring: y<0 subtracts
                if (dir_pos)
                begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                end
                else
                begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                end
                if (dir_pos)
                    cz_reg <= cz_reg - at;
                else
                    cz_reg <= cz_reg + at;
                if (!sts.cordic_done)
                    cstep_reg <= cstep_reg + 5'd1;
            end
            if (cmd.polar_fix)
            begin
                unique case (quad_reg)
                    2'd0: begin nx_reg <= sat20(rx);  ny_reg <= sat20(ry);  end
                    2'd1: begin nx_reg <= sat20(-ry); ny_reg <= sat20(rx);  end
                    2'd2: begin nx_reg <= sat20(-rx); ny_reg <= sat20(-ry); end
                    default: begin nx_reg <= sat20(ry); ny_reg <= sat20(-rx); end
                endcase
            end
            if (cmd.ring_write)
            begin
                wpos_reg <= (wpos_reg == PW'(WINDOW_MAX - 1)) ? '0 : wpos_reg + PW'(1);
                if (fill_reg < CW'(WINDOW_MAX))
                    fill_reg <= fill_reg + CW'(1);
                ridx_reg <= wpos_reg;
            end
            if (cmd.ema_update && sv_reg)
            begin
                ema_seeded_reg <= 1'b1;
                if (!ema_seeded_reg)
                    ema_acc_reg <= 32'(smp_reg) <<< 16;
                else
                    ema_acc_reg <= 32'(ema_shift);
            end
            if (cmd.walk_start)
            begin
                k_reg     <= '0;
                nsma_reg  <= wlen(sma_window, fill_reg);
                nwind_reg <= wlen(wind_window, fill_reg);
                sum_reg   <= '0;
                cnt_reg   <= '0;
                sx_reg    <= '0;
                sy_reg    <= '0;
                any_reg   <= 1'b0;
                if (ema_seeded_reg)
                begin
                    if (ema_rnd > 33'sd32767) ema_value <= 16'sh7fff;
                    else if (ema_rnd < -33'sd32768) ema_value <= -16'sh8000;
                    else ema_value <= 16'(ema_rnd);
                end
                else
                    ema_value <= '0;
            end
            else if (cmd.walk_step && !sts.walk_done)
            begin
                if (k_reg < nsma_reg && smp_ok_mem[ridx_reg])
                begin
                    sum_reg <= sum_reg + SW'(smp_mem[ridx_reg]);
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (k_reg < nwind_reg && wok_mem[ridx_reg])
                begin
                    sx_reg  <= sx_reg + XW'(wx_mem[ridx_reg]);
                    sy_reg  <= sy_reg + XW'(wy_mem[ridx_reg]);
                    any_reg <= 1'b1;
                end
                k_reg    <= k_reg + CW'(1);
                ridx_reg <= (ridx_reg == '0) ? PW'(WINDOW_MAX - 1) : prev_idx;
            end
            // restoring divide of (2|sum|+cnt) by 2cnt
            if (cmd.div_start)
            begin
                dneg_reg <= sum_reg[SW-1];
                dnum_reg <= DW'({(sum_reg[SW-1] ? -sum_reg : sum_reg), 1'b0})
                          + DW'(cnt_reg);
                dden_reg <= {cnt_reg, 1'b0};
                rem_reg  <= '0;
                quo_reg  <= '0;
                dbit_reg <= 6'(DW);
                mean_count <= 5'(cnt_reg);
            end
            else if (cmd.div_step && !sts.div_done)
            begin
                dnum_reg <= dnum_reg << 1;
                if (rem_sh >= DW'(dden_reg))
                begin
                    rem_reg <= rem_sh - DW'(dden_reg);
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                dbit_reg <= dbit_reg - 6'd1;
            end
            else if (cmd.div_step)
            begin
                if (mean_count == 5'd0)
                    mean_value <= '0;
                else
                    mean_value <= dneg_reg ? -16'(quo_reg) : 16'(quo_reg);
            end
            if (cmd.deg_calc)
            begin
                if (!any_reg || (sx_reg == 0 && sy_reg == 0))
                begin
                    wind_dir_avg  <= dreg_mod;
                    wind_fallback <= 1'b1;
                end
                else
                begin
                    wind_dir_avg  <= (zdeg_full < 0) ? 9'(zdeg_full + 34'sd360)
                                                     : 9'(zdeg_full);
                    wind_fallback <= 1'b0;
                end
            end
        end
    end

    // ring writes
    always_ff @(posedge clk)
    begin
        if (cmd.ring_write)
        begin
            smp_mem[wpos_reg]    <= smp_reg;
            smp_ok_mem[wpos_reg] <= sv_reg;
            wok_mem[wpos_reg]    <= wok_reg;
            wx_mem[wpos_reg]     <= wok_reg ? nx_reg : '0;
            wy_mem[wpos_reg]     <= wok_reg ? ny_reg : '0;
        end
    end

endmodule

// ----- rtl/windowed_and_exponential_smoother.sv -----
// each input beat passes through polar cordic rotation, a window walk, a restoring
//   divide and cordic vectoring before its result is offered
// flow: one item at a time; the next beat can be taken in the cycle after the result
//   is taken
// reset: asynchronous active low; clears fill count, write pointer and ema state, and
//   sets the config registers (sma_window 10, wind_window 15, alpha 13107)
module windowed_and_exponential_smoother
    import waes_pkg::*;
#(
    parameter int WINDOW_MAX   = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] sample,
    input  logic               sample_valid,
    input  logic [8:0]         wind_dir_deg,
    input  logic               wind_dir_valid,
    input  logic [11:0]        wind_speed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] mean_value,
    output logic [4:0]         mean_count,
    output logic signed [15:0] ema_value,
    output logic [8:0]         wind_dir_avg,
    output logic               wind_fallback
);

    logic [4:0]  sma_reg, wind_reg;
    logic [16:0] alpha_reg;
    waes_cmd_t   cmd;
    waes_sts_t   sts;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sma_reg   <= 5'd10;
            wind_reg  <= 5'd15;
            alpha_reg <= 17'd13107;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SMA_WINDOW:  sma_reg   <= cfg_data[4:0];
                REG_WIND_WINDOW: wind_reg  <= cfg_data[4:0];
                REG_ALPHA:       alpha_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    waes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    waes_dp #(
        .WINDOW_MAX   (WINDOW_MAX),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .sma_window     (sma_reg),
        .wind_window    (wind_reg),
        .alpha          (alpha_reg),
        .sample         (sample),
        .sample_valid   (sample_valid),
        .wind_dir_deg   (wind_dir_deg),
        .wind_dir_valid (wind_dir_valid),
        .wind_speed     (wind_speed),
        .mean_value     (mean_value),
        .mean_count     (mean_count),
        .ema_value      (ema_value),
        .wind_dir_avg   (wind_dir_avg),
        .wind_fallback  (wind_fallback)
    );

endmodule

// ----- rtl/waes_checker.sv -----
module waes_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] mean_count,
    input logic [8:0] wind_dir_avg
);

    // output valid and wind_dir_avg hold while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(wind_dir_avg))
        else $error("stalled result changed");

    // no new input while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // an accepted beat is not immediately a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid && in_stall)
        else $error("result too early");

    // ranges of result fields
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wind_dir_avg < 9'd360) && (mean_count <= 5'd16))
        else $error("result out of range");

endmodule

bind windowed_and_exponential_smoother waes_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mean_count   (mean_count),
    .wind_dir_avg (wind_dir_avg)
);

// ----- test/tb_windowed_and_exponential_smoother.sv -----
`timescale 1ns / 1ps

module tb_windowed_and_exponential_smoother;
    import waes_pkg::*;

    typedef struct {
        logic signed [15:0] mean_value;
        logic [4:0]         mean_count;
        logic signed [15:0] ema_value;
        logic [8:0]         wind_dir_avg;
        logic               wind_fallback;
    } smoother_result_t;

    localparam int DEPTH = 16;
    localparam int ROTATIONS = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    // scoreboard: keeps its own copy of the smoother state and the pending results
    class smoother_scoreboard;
        smoother_result_t pending[$];
        int errors;
        longint sample_hist[DEPTH];
        bit sample_ok[DEPTH];
        longint wind_x[DEPTH];
        longint wind_y[DEPTH];
        bit wind_ok[DEPTH];
        int fill;
        int wpos;
        longint ema_acc;
        bit ema_seeded;
        int sma_window;
        int wind_window;
        longint alpha;
        longint atan_tab[ROTATIONS];

        function new();
            atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772,
                         166886, 83443, 41722, 20861};
            errors = 0;
            fill = 0;
            wpos = 0;
            ema_acc = 0;
            ema_seeded = 0;
            sma_window = 10;
            wind_window = 15;
            alpha = 13107;
        endfunction

        function void set_reg(waes_reg_t idx, logic [16:0] data);
            case (idx)
                REG_SMA_WINDOW:  sma_window = data[4:0];
                REG_WIND_WINDOW: wind_window = data[4:0];
                REG_ALPHA:       alpha = data;
                default: ;
            endcase
        endfunction

        function int span(int reg_val);
            int n;
            n = (reg_val == 0) ? 1 : reg_val;
            if (n > DEPTH) n = DEPTH;
            if (n > fill) n = fill;
            return n;
        endfunction

        // speed and direction to a rounded x/y vector
        function void wind_vector(int dir, int spd, output longint ox, output longint oy);
            int d, q, r;
            longint x, y, z, nx, ny, c, s;
            d = dir % 360;
            q = d / 90;
            r = d % 90;
            z = ((longint'(r) << 32) + 180) / 360;
            x = (longint'(spd) * longint'({32'b0, INV_GAIN_Q32})) >> (32 - 7 - GUARD_BITS);
            y = 0;
            for (int i = 0; i < ROTATIONS; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z = z - atan_tab[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z = z + atan_tab[i];
                end
                x = nx;
                y = ny;
            end
            x = (x + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
            y = (y + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
            case (q)
                0: begin c = x;  s = y;  end
                1: begin c = -y; s = x;  end
                2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            if (c > XY_LIMIT) c = XY_LIMIT;
            if (c < -XY_LIMIT) c = -XY_LIMIT;
            if (s > XY_LIMIT) s = XY_LIMIT;
            if (s < -XY_LIMIT) s = -XY_LIMIT;
            ox = c;
            oy = s;
        endfunction

        // vector sum to degrees by vectoring rotations
        function int heading_deg(longint sx, longint sy);
            longint x, y, z, nx, ny, deg;
            x = sx * 4096;
            y = sy * 4096;
            z = 0;
            if (x < 0)
            begin
                z = (y >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < ROTATIONS; i++)
            begin
                if (y < 0)
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z = z - atan_tab[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z = z + atan_tab[i];
                end
                x = nx;
                y = ny;
            end
            deg = (z * 360) / 64'sd4294967296;
            if (deg < 0) deg += 360;
            return int'(deg % 360);
        endfunction

        // accepted input beat: update state and queue the expected result
        function void note_input(logic signed [15:0] smp, logic sv, logic [8:0] dir,
                                 logic dv, logic [11:0] spd);
            smoother_result_t res;
            int pos, n, idx, cnt;
            longint sum, sx, sy, a, v, xs, eo, mag, qv;
            bit any;
            pos = wpos;
            sample_hist[pos] = smp;
            sample_ok[pos] = sv;
            wind_ok[pos] = dv && (spd != 0);
            if (wind_ok[pos])
                wind_vector(dir, spd, wind_x[pos], wind_y[pos]);
            else
            begin
                wind_x[pos] = 0;
                wind_y[pos] = 0;
            end
            wpos = (pos + 1) % DEPTH;
            if (fill < DEPTH) fill++;

            // exponential smoother
            if (sv)
            begin
                xs = longint'(smp) * 65536;
                if (!ema_seeded)
                begin
                    ema_acc = xs;
                    ema_seeded = 1;
                end
                else
                begin
                    a = (alpha > 65536) ? 65536 : alpha;
                    v = a * xs + (65536 - a) * ema_acc + 32768;
                    ema_acc = v >>> 16;
                end
            end
            eo = 0;
            if (ema_seeded)
            begin
                eo = (ema_acc + 32768) >>> 16;
                if (eo > 32767) eo = 32767;
                if (eo < -32768) eo = -32768;
            end

            // windowed mean
            sum = 0;
            cnt = 0;
            n = span(sma_window);
            for (int k = 0; k < n; k++)
            begin
                idx = (pos + DEPTH - k) % DEPTH;
                if (sample_ok[idx])
                begin
                    sum += sample_hist[idx];
                    cnt++;
                end
            end
            qv = 0;
            if (cnt > 0)
            begin
                mag = (sum < 0) ? -sum : sum;
                qv = (2 * mag + cnt) / (2 * cnt);
                if (sum < 0) qv = -qv;
            end

            // wind vector average
            sx = 0;
            sy = 0;
            any = 0;
            n = span(wind_window);
            for (int k = 0; k < n; k++)
            begin
                idx = (pos + DEPTH - k) % DEPTH;
                if (wind_ok[idx])
                begin
                    sx += wind_x[idx];
                    sy += wind_y[idx];
                    any = 1;
                end
            end

            res.mean_value = qv[15:0];
            res.mean_count = cnt[4:0];
            res.ema_value = eo[15:0];
            res.wind_fallback = !any || (sx == 0 && sy == 0);
            res.wind_dir_avg = res.wind_fallback ? 9'(dir % 360) : 9'(heading_deg(sx, sy));
            pending.push_back(res);
        endfunction

        function void check_result(smoother_result_t got);
            smoother_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result beat with no expected result waiting");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.mean_value !== exp_r.mean_value)
            begin
                $error("mean_value expected %0d actual %0d", exp_r.mean_value, got.mean_value);
                errors++;
            end
            if (got.mean_count !== exp_r.mean_count)
            begin
                $error("mean_count expected %0d actual %0d", exp_r.mean_count, got.mean_count);
                errors++;
            end
            if (got.ema_value !== exp_r.ema_value)
            begin
                $error("ema_value expected %0d actual %0d", exp_r.ema_value, got.ema_value);
                errors++;
            end
            if (got.wind_dir_avg !== exp_r.wind_dir_avg)
            begin
                $error("wind_dir_avg expected %0d actual %0d",
                       exp_r.wind_dir_avg, got.wind_dir_avg);
                errors++;
            end
            if (got.wind_fallback !== exp_r.wind_fallback)
            begin
                $error("wind_fallback expected %0d actual %0d",
                       exp_r.wind_fallback, got.wind_fallback);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [16:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sample;
    logic               sample_valid;
    logic [8:0]         wind_dir_deg;
    logic               wind_dir_valid;
    logic [11:0]        wind_speed;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] mean_value;
    logic [4:0]         mean_count;
    logic signed [15:0] ema_value;
    logic [8:0]         wind_dir_avg;
    logic               wind_fallback;

    smoother_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    longint cycle_count;

    windowed_and_exponential_smoother uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .sample_valid   (sample_valid),
        .wind_dir_deg   (wind_dir_deg),
        .wind_dir_valid (wind_dir_valid),
        .wind_speed     (wind_speed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mean_value     (mean_value),
        .mean_count     (mean_count),
        .ema_value      (ema_value),
        .wind_dir_avg   (wind_dir_avg),
        .wind_fallback  (wind_fallback)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
        out_stall = ($urandom_range(99) < receiver_stall_pct);

    // result monitor
    always @(posedge clk)
    begin
        smoother_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.mean_value = mean_value;
            got.mean_count = mean_count;
            got.ema_value = ema_value;
            got.wind_dir_avg = wind_dir_avg;
            got.wind_fallback = wind_fallback;
            sb.check_result(got);
        end
    end

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(waes_reg_t idx, logic [16:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_beat(logic signed [15:0] smp, logic sv, logic [8:0] dir,
                             logic dv, logic [11:0] spd);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample = smp;
        sample_valid = sv;
        wind_dir_deg = dir;
        wind_dir_valid = dv;
        wind_speed = spd;
        forever
        begin
            @(posedge clk);
            if (!in_stall) break;
        end
        sb.note_input(smp, sv, dir, dv, spd);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_random();
        logic signed [15:0] smp;
        logic [8:0] dir;
        logic [11:0] spd;
        case ($urandom_range(9))
            0: smp = 16'sh7FFF;
            1: smp = 16'sh8000;
            2: smp = 16'($urandom_range(64)) - 16'sd32;
            default: smp = 16'($urandom);
        endcase
        dir = ($urandom_range(9) == 0) ? 9'($urandom_range(511, 360)) : 9'($urandom_range(359));
        case ($urandom_range(9))
            0: spd = 12'd0;
            1: spd = 12'hFFF;
            2: spd = 12'($urandom_range(8, 1));
            default: spd = 12'($urandom);
        endcase
        send_beat(smp, $urandom_range(99) < 75, dir, $urandom_range(99) < 80, spd);
    endtask

    initial
    begin
        int sma_set[8];
        int wind_set[8];
        int alpha_set[8];
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SMA_WINDOW;
        cfg_data = '0;
        in_valid = 1'b0;
        sample = '0;
        sample_valid = 1'b0;
        wind_dir_deg = '0;
        wind_dir_valid = 1'b0;
        wind_speed = '0;
        out_stall = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed: unseeded smoother, no wind entry, cancelling vectors, extremes
        send_beat(16'sd100, 1'b0, 9'd45, 1'b0, 12'd50);
        send_beat(16'sd0, 1'b0, 9'd0, 1'b1, 12'd100);
        send_beat(16'sd16, 1'b1, 9'd180, 1'b1, 12'd100);
        send_beat(16'sh7FFF, 1'b1, 9'd90, 1'b1, 12'hFFF);
        send_beat(16'sh7FFF, 1'b1, 9'd270, 1'b1, 12'hFFF);
        send_beat(16'sh8000, 1'b1, 9'd359, 1'b1, 12'd1);
        send_beat(16'sh8000, 1'b1, 9'd511, 1'b1, 12'hFFF);
        send_beat(-16'sd3, 1'b1, 9'd360, 1'b1, 12'd7);
        send_beat(16'sd5, 1'b1, 9'd89, 1'b0, 12'hFFF);
        send_beat(16'sd0, 1'b1, 9'd1, 1'b1, 12'd0);
        send_beat(-16'sd1, 1'b1, 9'd179, 1'b1, 12'd2048);
        send_beat(16'sd1, 1'b1, 9'd181, 1'b1, 12'd2048);
        wait_drained();

        // edges of the register ranges
        write_reg(REG_SMA_WINDOW, 17'd0);
        write_reg(REG_WIND_WINDOW, 17'd0);
        write_reg(REG_ALPHA, 17'd0);
        send_beat(16'sd40, 1'b1, 9'd10, 1'b1, 12'd30);
        send_beat(-16'sd40, 1'b1, 9'd190, 1'b1, 12'd30);
        send_beat(16'sd7, 1'b1, 9'd300, 1'b1, 12'd4);
        wait_drained();
        write_reg(REG_SMA_WINDOW, 17'd31);
        write_reg(REG_WIND_WINDOW, 17'd17);
        write_reg(REG_ALPHA, 17'h1FFFF);
        send_beat(16'sd9, 1'b1, 9'd0, 1'b1, 12'd10);
        send_beat(16'sd11, 1'b1, 9'd180, 1'b1, 12'd10);
        send_beat(-16'sd2, 1'b1, 9'd270, 1'b0, 12'd10);
        wait_drained();

        // random phases over several register settings and idle patterns
        sma_set   = '{1, 16, 10, 0, 31, 5, 3, 16};
        wind_set  = '{1, 16, 15, 2, 0, 31, 7, 16};
        alpha_set = '{65536, 0, 13107, 1, 131071, 40000, 65535, 32768};
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            write_reg(REG_SMA_WINDOW, 17'(sma_set[ph]));
            write_reg(REG_WIND_WINDOW, 17'(wind_set[ph]));
            write_reg(REG_ALPHA, 17'(alpha_set[ph]));
            if (ph < 3)
            begin
                sender_idle_pct = 30;
                receiver_stall_pct = 64;
            end
            else if (ph < 6)
            begin
                sender_idle_pct = 64;
                receiver_stall_pct = 30;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            for (int k = 0; k < 230; k++)
            begin
                // hold off until the block has handed back everything
                if (k == 115)
                    while (sb.pending.size() != 0)
                        @(negedge clk);
                send_random();
            end
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/waes_pkg.sv
rtl/waes_ctrl.sv
rtl/waes_dp.sv
rtl/windowed_and_exponential_smoother.sv
rtl/waes_checker.sv
test/tb_windowed_and_exponential_smoother.sv
